FILE: src/rpq_pkg.sv
// ============================================================================
// rpq_pkg
// Shared types, constants and lookup tables for the RGB565 palette quantizer.
// ============================================================================
`default_nettype none

package rpq_pkg;

  // Field widths.
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SQ_W      = 16;  // 255*255 fits in 16 bits
  localparam int unsigned WSQ_W     = 22;  // 59*255*255 fits in 22 bits
  localparam int unsigned DIST_W    = 23;  // 100*255*255 fits in 23 bits
  localparam int unsigned LUM_W     = 15;  // 100*255 fits in 15 bits
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned NUM_COLORS = 6;

  // Expansion divisors and full-scale channel value.
  localparam int unsigned Max5    = 31;
  localparam int unsigned Max6    = 63;
  localparam int unsigned FullVal = 255;

  // Luminance and distance weights.
  localparam int unsigned WT_R = 30;
  localparam int unsigned WT_G = 59;
  localparam int unsigned WT_B = 11;
  localparam int unsigned THR_SCALE = 100;
  localparam logic [7:0] THR_RESET = 8'd180;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [WSQ_W-1:0]   wsq_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [LUM_W-1:0]   lum_t;
  typedef logic [CODE_W-1:0]  color_code_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Color codes.
  localparam color_code_t CODE_WHITE  = 3'd0;
  localparam color_code_t CODE_BLACK  = 3'd1;
  localparam color_code_t CODE_RED    = 3'd2;
  localparam color_code_t CODE_YELLOW = 3'd3;
  localparam color_code_t CODE_GREEN  = 3'd4;
  localparam color_code_t CODE_BLUE   = 3'd5;

  // Register indexes.
  localparam cfg_idx_t REG_PALETTE_MODE   = 1'd0;
  localparam cfg_idx_t REG_MONO_THRESHOLD = 1'd1;

  // Palette colors: each channel is either 0 or full scale. Bit 2 is red,
  // bit 1 green, bit 0 blue; a set bit means the channel is at full scale.
  typedef logic [2:0] pal_mask_t;
  localparam pal_mask_t PAL_HI [NUM_COLORS] = '{
    3'b111,  // white
    3'b000,  // black
    3'b100,  // red
    3'b110,  // yellow
    3'b010,  // green
    3'b001   // blue
  };

  // Load enables for the two selection stages.
  typedef struct packed {
    logic ld4;
    logic ld5;
  } rpq_stg_ctl_t;

  // Expansion tables, built at elaboration.
  typedef chan_t exp5_lut_t [32];
  typedef chan_t exp6_lut_t [64];

  function automatic exp5_lut_t build_exp5();
    exp5_lut_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = CHAN_W'((i * FullVal) / Max5);
    end
    return t;
  endfunction

  function automatic exp6_lut_t build_exp6();
    exp6_lut_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = CHAN_W'((i * FullVal) / Max6);
    end
    return t;
  endfunction

  localparam exp5_lut_t EXP5_LUT = build_exp5();
  localparam exp6_lut_t EXP6_LUT = build_exp6();

endpackage

`default_nettype wire

FILE: src/rpq_if.sv
// ============================================================================
// rpq_if
// Valid/ready channel interfaces for pixel requests and color code results.
// ============================================================================
`default_nettype none

interface rpq_pixel_if;
  import rpq_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_rgb565;

  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

interface rpq_code_if;
  import rpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] color_code;

  modport source (output valid, output color_code, input ready);
  modport sink   (input valid, input color_code, output ready);
endinterface

`default_nettype wire

FILE: src/rpq_min6.sv
// ============================================================================
// rpq_min6
// Two-stage selection of the nearest palette entry, plus mono/palette mux.
// ============================================================================
`default_nettype none

module rpq_min6 (
  input  wire logic                  clk,
  input  wire rpq_pkg::rpq_stg_ctl_t ctl,
  input  wire rpq_pkg::dist_t        pal_dist [rpq_pkg::NUM_COLORS],
  input  wire logic                  mono_black,
  input  wire logic                  palette_mode,
  output      rpq_pkg::color_code_t  color_code
);
  import rpq_pkg::*;

  localparam int unsigned NUM_PAIRS = NUM_COLORS / 2;

  dist_t       pair_d_r    [NUM_PAIRS];
  color_code_t pair_c_r    [NUM_PAIRS];
  dist_t       pair_d_nxt  [NUM_PAIRS];
  color_code_t pair_c_nxt  [NUM_PAIRS];
  logic        mono_black_r;
  color_code_t code_r;
  color_code_t code_nxt;

  // First round: the odd entry replaces its even partner only if strictly nearer.
  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (pal_dist[2*p+1] < pal_dist[2*p]) begin
        pair_d_nxt[p] = pal_dist[2*p+1];
        pair_c_nxt[p] = CODE_W'(2*p+1);
      end else begin
        pair_d_nxt[p] = pal_dist[2*p];
        pair_c_nxt[p] = CODE_W'(2*p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      pair_d_r     <= pair_d_nxt;
      pair_c_r     <= pair_c_nxt;
      mono_black_r <= mono_black;
    end
  end

  // Second round: later pairs win only on a strictly smaller distance.
  always_comb begin
    dist_t best_d;
    best_d   = pair_d_r[0];
    code_nxt = pair_c_r[0];
    for (int p = 1; p < NUM_PAIRS; p++) begin
      if (pair_d_r[p] < best_d) begin
        best_d   = pair_d_r[p];
        code_nxt = pair_c_r[p];
      end
    end
    if (!palette_mode) begin
      code_nxt = mono_black_r ? CODE_BLACK : CODE_WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      code_r <= code_nxt;
    end
  end

  assign color_code = code_r;

endmodule

`default_nettype wire

FILE: src/rgb565_palette_quantizer.sv
// ============================================================================
// rgb565_palette_quantizer
// Maps RGB565 pixels to panel color codes by luminance threshold or by the
// nearest of six palette colors under a 30/59/11 weighted squared distance.
// ============================================================================
// Throughput: one pixel per cycle through a five-stage pipeline (expand,
// square, weight and sum, pair select, final select); on a stall, each full
// stage whose successor is held keeps its data, while empty stages still load.
// Reset: synchronous, active low; clears all valid bits, sets palette_mode to
// 0 and mono_threshold to 180.
`default_nettype none

module rgb565_palette_quantizer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rpq_pixel_if.sink                 in_px,
  rpq_code_if.source                out_cc,
  input  wire logic                 cfg_we,
  input  wire rpq_pkg::cfg_idx_t    cfg_index,
  input  wire logic [rpq_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import rpq_pkg::*;

  // Configuration registers.
  logic  palette_mode_r;
  chan_t mono_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_mode_r   <= 1'b0;
      mono_threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PALETTE_MODE:   palette_mode_r   <= cfg_wdata[0];
        REG_MONO_THRESHOLD: mono_threshold_r <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  rpq_stg_ctl_t sel_ctl;

  assign rdy5 = !v5_r || out_cc.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_px.ready  = rdy1;
  assign out_cc.valid = v5_r;
  assign sel_ctl.ld4  = rdy4;
  assign sel_ctl.ld5  = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_px.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: widen the channel fields to 8 bits through the expansion tables.
  chan_t r1_r, g1_r, b1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1_r <= EXP5_LUT[in_px.pixel_rgb565[15:11]];
      g1_r <= EXP6_LUT[in_px.pixel_rgb565[10:5]];
      b1_r <= EXP5_LUT[in_px.pixel_rgb565[4:0]];
    end
  end

  // Stage 2: squared distances to zero and to full scale per channel, and
  // the luminance threshold decision.
  sq_t  sq_lr_r, sq_lg_r, sq_lb_r, sq_hr_r, sq_hg_r, sq_hb_r;
  logic black2_r;
  chan_t ir1, ig1, ib1;
  lum_t lum1, thr1;

  assign ir1 = chan_t'(FullVal) - r1_r;
  assign ig1 = chan_t'(FullVal) - g1_r;
  assign ib1 = chan_t'(FullVal) - b1_r;
  assign lum1 = LUM_W'(r1_r) * LUM_W'(WT_R) + LUM_W'(g1_r) * LUM_W'(WT_G)
              + LUM_W'(b1_r) * LUM_W'(WT_B);
  assign thr1 = LUM_W'(mono_threshold_r) * LUM_W'(THR_SCALE);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sq_lr_r  <= SQ_W'(r1_r) * SQ_W'(r1_r);
      sq_lg_r  <= SQ_W'(g1_r) * SQ_W'(g1_r);
      sq_lb_r  <= SQ_W'(b1_r) * SQ_W'(b1_r);
      sq_hr_r  <= SQ_W'(ir1) * SQ_W'(ir1);
      sq_hg_r  <= SQ_W'(ig1) * SQ_W'(ig1);
      sq_hb_r  <= SQ_W'(ib1) * SQ_W'(ib1);
      black2_r <= (lum1 < thr1);
    end
  end

  // Stage 3: weight the squares and add up the distance to each palette color.
  wsq_t  w_lr, w_lg, w_lb, w_hr, w_hg, w_hb;
  dist_t dist3_nxt [NUM_COLORS];
  dist_t dist3_r   [NUM_COLORS];
  logic  black3_r;

  assign w_lr = WSQ_W'(sq_lr_r) * WSQ_W'(WT_R);
  assign w_lg = WSQ_W'(sq_lg_r) * WSQ_W'(WT_G);
  assign w_lb = WSQ_W'(sq_lb_r) * WSQ_W'(WT_B);
  assign w_hr = WSQ_W'(sq_hr_r) * WSQ_W'(WT_R);
  assign w_hg = WSQ_W'(sq_hg_r) * WSQ_W'(WT_G);
  assign w_hb = WSQ_W'(sq_hb_r) * WSQ_W'(WT_B);

  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      dist3_nxt[i] = DIST_W'(PAL_HI[i][2] ? w_hr : w_lr)
                   + DIST_W'(PAL_HI[i][1] ? w_hg : w_lg)
                   + DIST_W'(PAL_HI[i][0] ? w_hb : w_lb);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dist3_r  <= dist3_nxt;
      black3_r <= black2_r;
    end
  end

  // Stages 4 and 5: nearest-color selection and output register.
  rpq_min6 u_min6 (
    .clk          (clk),
    .ctl          (sel_ctl),
    .pal_dist     (dist3_r),
    .mono_black   (black3_r),
    .palette_mode (palette_mode_r),
    .color_code   (out_cc.color_code)
  );

endmodule

`default_nettype wire
